// ===== hw/rtl/buddy_block_allocator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Buddy allocator assertion macros
// Short forms for the concurrent checks used in the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Check that is switched off while the reset is asserted.
`define BBA_ASSERT(label, clk_s, rst_s, prop, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
		else $error(msg);

// Check that holds at every edge, including during reset.
`define BBA_ASSERT_ALWAYS(label, clk_s, prop, msg) \
	label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== hw/rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator package
// Shared constants, codes and beat payload types of the buddy allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int MAX_ORDER_DEF       = 7;
	localparam int MIN_BLOCK_BYTES_DEF = 32;

	localparam logic [1:0] NODE_UNUSED = 2'd0;
	localparam logic [1:0] NODE_FREE   = 2'd1;
	localparam logic [1:0] NODE_SPLIT  = 2'd2;
	localparam logic [1:0] NODE_ALLOC  = 2'd3;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_BAD_SIZE  = 2'd1;
	localparam logic [1:0] STAT_NO_ROOM   = 2'd2;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic        mode;
		logic [12:0] req_size;
		logic [11:0] block_offset;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [1:0]  status;
		logic [11:0] result_offset;
		logic [12:0] block_bytes;
	} rsp_t;

endpackage

// ===== hw/rtl/bba_stream_if.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator stream interface
// Valid and ready handshake channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface bba_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/bba_ram.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator RAM
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 255
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/buddy_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator
// Binary buddy allocator that keeps its heap as a tree of node states in RAM.
// ----------------------------------------------------------------------------
// One request beat is taken at a time, and the result beat is held until it is
// taken. Every node access goes through the single port pair of the node RAM,
// so cost follows the tree walk. An allocate reads each node visited by the
// leftmost search, steps across to a sibling or back up to a parent, then
// splits each level below the free block it takes and marks the block. A
// free reads each level on the way down, then clears each free buddy pair
// and marks their parent free, and ends with a last buddy check. After reset
// a clearing pass writes all 2^(MAX_ORDER+1)-1 nodes, 255 by default, before
// the first request is taken.
`include "buddy_block_allocator_unit_assert.svh"

module buddy_block_allocator_unit #(
	parameter int MAX_ORDER       = bba_pkg::MAX_ORDER_DEF,
	parameter int MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	bba_stream_if.sink    req,
	bba_stream_if.source  rsp
);
	import bba_pkg::*;

	localparam int NODE_COUNT = (1 << (MAX_ORDER + 1)) - 1;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int DEP_W      = $clog2(MAX_ORDER + 1);
	localparam int HEAP_BYTES = MIN_BLOCK_BYTES * (1 << MAX_ORDER);
	localparam int OFF_W      = $clog2(HEAP_BYTES + 1);
	localparam int CMP_W      = ((OFF_W > 13) ? OFF_W : 13) + 1;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RD    = 4'd2;
	localparam logic [3:0] S_EV    = 4'd3;
	localparam logic [3:0] S_BACK  = 4'd4;
	localparam logic [3:0] S_TAKE  = 4'd5;
	localparam logic [3:0] S_TAKE2 = 4'd6;
	localparam logic [3:0] S_MRD   = 4'd7;
	localparam logic [3:0] S_MEV   = 4'd8;
	localparam logic [3:0] S_MW2   = 4'd9;
	localparam logic [3:0] S_MW3   = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	logic [3:0]        state_q;
	logic              mode_q;
	logic [11:0]       offset_q;
	logic [NODE_W-1:0] node_q;
	logic [NODE_W-1:0] clr_q;
	logic [DEP_W-1:0]  dep_q;
	logic [DEP_W-1:0]  tgt_q;
	logic [OFF_W-1:0]  off_q;
	logic [OFF_W-1:0]  sz_q;
	logic [1:0]        rsp_status_q;
	logic [OFF_W-1:0]  rsp_off_q;
	logic [OFF_W-1:0]  rsp_bytes_q;

	logic              we;
	logic [NODE_W-1:0] waddr;
	logic [1:0]        wdata;
	logic [NODE_W-1:0] raddr;
	logic [1:0]        rdata;

	logic [NODE_W-1:0] child_l;
	logic [NODE_W-1:0] parent;
	logic [NODE_W-1:0] buddy;
	logic [DEP_W-1:0]  ord_d;
	logic              ord_fnd;
	logic [CMP_W-1:0]  size_ext;
	logic [CMP_W-1:0]  offset_ext;
	logic [CMP_W-1:0]  mid_ext;
	logic [OFF_W-1:0]  half;

	assign child_l    = {node_q[NODE_W-2:0], 1'b1};
	assign parent     = (node_q - NODE_W'(1)) >> 1;
	assign buddy      = node_q[0] ? (node_q + NODE_W'(1)) : (node_q - NODE_W'(1));
	assign half       = sz_q >> 1;
	assign size_ext   = CMP_W'(req.payload.req_size);
	assign offset_ext = CMP_W'(offset_q);
	assign mid_ext    = CMP_W'(off_q) + CMP_W'(half);

	always_comb begin
		ord_d   = '0;
		ord_fnd = 1'b0;
		for (int i = MAX_ORDER; i >= 0; i--) begin
			if (size_ext < (CMP_W'(MIN_BLOCK_BYTES) << i)) begin
				ord_d   = DEP_W'(i);
				ord_fnd = 1'b1;
			end
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = node_q;
		wdata = NODE_UNUSED;
		raddr = node_q;
		unique case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = (clr_q == '0) ? NODE_FREE : NODE_UNUSED;
			end
			S_EV: begin
				if (mode_q && rdata == NODE_ALLOC && CMP_W'(off_q) == offset_ext) begin
					we    = 1'b1;
					wdata = NODE_FREE;
				end
			end
			S_TAKE: begin
				we    = 1'b1;
				wdata = (dep_q == tgt_q) ? NODE_ALLOC : NODE_SPLIT;
			end
			S_TAKE2: begin
				we    = 1'b1;
				waddr = child_l + NODE_W'(1);
				wdata = NODE_FREE;
			end
			S_MRD: begin
				raddr = buddy;
			end
			S_MEV: begin
				we    = (rdata == NODE_FREE);
				wdata = NODE_UNUSED;
			end
			S_MW2: begin
				we    = 1'b1;
				waddr = buddy;
				wdata = NODE_UNUSED;
			end
			S_MW3: begin
				we    = 1'b1;
				waddr = parent;
				wdata = NODE_FREE;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	bba_ram #(
		.WIDTH(2),
		.DEPTH(NODE_COUNT)
	) u_node_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + NODE_W'(1);
					if (clr_q == NODE_W'(NODE_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_RD;
						if (!req.payload.mode && (req.payload.req_size == '0 || !ord_fnd)) begin
							state_q <= S_DONE;
						end
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (mode_q) begin
						if (rdata == NODE_ALLOC && CMP_W'(off_q) == offset_ext) begin
							state_q <= S_MRD;
						end else if (rdata == NODE_SPLIT && dep_q != tgt_q) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_DONE;
						end
					end else if (rdata == NODE_FREE) begin
						state_q <= S_TAKE;
					end else if (rdata == NODE_SPLIT && dep_q != tgt_q) begin
						state_q <= S_RD;
					end else begin
						state_q <= S_BACK;
					end
				end
				S_BACK: begin
					if (node_q == '0) begin
						state_q <= S_DONE;
					end else if (node_q[0]) begin
						state_q <= S_RD;
					end
				end
				S_TAKE: begin
					state_q <= (dep_q == tgt_q) ? S_DONE : S_TAKE2;
				end
				S_TAKE2: begin
					state_q <= S_TAKE;
				end
				S_MRD: begin
					state_q <= (node_q == '0) ? S_DONE : S_MEV;
				end
				S_MEV: begin
					state_q <= (rdata == NODE_FREE) ? S_MW2 : S_DONE;
				end
				S_MW2: begin
					state_q <= S_MW3;
				end
				S_MW3: begin
					state_q <= S_MRD;
				end
				S_DONE: begin
					if (rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				mode_q       <= req.payload.mode;
				offset_q     <= req.payload.block_offset;
				node_q       <= '0;
				dep_q        <= '0;
				off_q        <= '0;
				sz_q         <= OFF_W'(HEAP_BYTES);
				tgt_q        <= req.payload.mode ? DEP_W'(MAX_ORDER) : DEP_W'(MAX_ORDER) - ord_d;
				rsp_status_q <= STAT_BAD_SIZE;
				rsp_off_q    <= '0;
				rsp_bytes_q  <= '0;
			end
			S_EV: begin
				if (mode_q) begin
					if (rdata == NODE_ALLOC && CMP_W'(off_q) == offset_ext) begin
						rsp_status_q <= STAT_OK;
						rsp_off_q    <= off_q;
						rsp_bytes_q  <= sz_q;
					end else if (rdata == NODE_SPLIT && dep_q != tgt_q) begin
						if (offset_ext >= mid_ext) begin
							node_q <= child_l + NODE_W'(1);
							off_q  <= off_q + half;
						end else begin
							node_q <= child_l;
						end
						sz_q  <= half;
						dep_q <= dep_q + DEP_W'(1);
					end else begin
						rsp_status_q <= STAT_NOT_FOUND;
					end
				end else if (rdata == NODE_SPLIT && dep_q != tgt_q) begin
					node_q <= child_l;
					sz_q   <= half;
					dep_q  <= dep_q + DEP_W'(1);
				end
			end
			S_BACK: begin
				if (node_q == '0) begin
					rsp_status_q <= STAT_NO_ROOM;
				end else if (node_q[0]) begin
					node_q <= node_q + NODE_W'(1);
					off_q  <= off_q + sz_q;
				end else begin
					node_q <= parent;
					off_q  <= off_q - sz_q;
					sz_q   <= sz_q << 1;
					dep_q  <= dep_q - DEP_W'(1);
				end
			end
			S_TAKE: begin
				if (dep_q == tgt_q) begin
					rsp_status_q <= STAT_OK;
					rsp_off_q    <= off_q;
					rsp_bytes_q  <= sz_q;
				end
			end
			S_TAKE2: begin
				node_q <= child_l;
				sz_q   <= half;
				dep_q  <= dep_q + DEP_W'(1);
			end
			S_MW3: begin
				node_q <= parent;
			end
			default: begin
				node_q <= node_q;
			end
		endcase
	end

	assign req.ready                  = (state_q == S_IDLE);
	assign rsp.valid                  = (state_q == S_DONE);
	assign rsp.payload.ok             = (rsp_status_q == STAT_OK);
	assign rsp.payload.status         = rsp_status_q;
	assign rsp.payload.result_offset  = 12'(rsp_off_q);
	assign rsp.payload.block_bytes    = 13'(rsp_bytes_q);

	`BBA_ASSERT_ALWAYS(a_clear_blocks_req, clk, (state_q == S_CLR) |-> !req.ready, "request taken during clearing pass")
	`BBA_ASSERT(a_accept_leaves_idle, clk, arst_n, (req.valid && req.ready) |=> (state_q != S_IDLE), "accepted beat left the block idle")
	`BBA_ASSERT(a_fail_is_zero, clk, arst_n, (rsp.valid && rsp_status_q != STAT_OK) |-> (rsp_off_q == '0 && rsp_bytes_q == '0), "failed result carries nonzero data")
	`BBA_ASSERT(a_depth_bound, clk, arst_n, (state_q != S_IDLE && state_q != S_CLR && state_q != S_DONE) |-> (dep_q <= tgt_q), "tree walk went below the target depth")

endmodule

// ===== test/tb_buddy_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate and free requests, predicts each result from a local tree
// of node states and compares every response beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_buddy_block_allocator_unit;
	import bba_pkg::*;

	localparam int ORDERS     = MAX_ORDER_DEF;
	localparam int MIN_BYTES  = MIN_BLOCK_BYTES_DEF;
	localparam int NODES      = (1 << (ORDERS + 1)) - 1;
	localparam int HEAP       = MIN_BYTES << ORDERS;
	localparam int CYCLE_CAP  = 5000000;

	logic clk;
	logic arst_n;

	bba_stream_if #(.payload_t(req_t)) req ();
	bba_stream_if #(.payload_t(rsp_t)) rsp ();

	buddy_block_allocator_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	logic [1:0] tree [NODES];
	rsp_t pending [$];
	int errors;
	int cycles;
	int send_idle_pct;
	int recv_idle_pct;
	logic [11:0] live_offsets [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_CAP) begin
				$display("tb_buddy_block_allocator_unit: errors");
				$finish;
			end
		end
	end

	function automatic int level_of(int n);
		int d;
		d = 0;
		while (d < ORDERS && ((1 << (d + 1)) - 1) <= n)
			d++;
		return d;
	endfunction

	function automatic bit slot_open(int d, int j);
		int n;
		n = 0;
		for (int k = 0; k <= d; k++) begin
			if (k == d)
				return tree[n] == NODE_FREE;
			if (tree[n] == NODE_FREE)
				return 1'b1;
			if (tree[n] != NODE_SPLIT)
				return 1'b0;
			n = 2 * n + 1 + ((j >> (d - 1 - k)) & 1);
		end
		return 1'b0;
	endfunction

	function automatic void claim_slot(int d, int j);
		int n;
		n = 0;
		for (int k = 0; k < d; k++) begin
			if (tree[n] == NODE_FREE) begin
				tree[n] = NODE_SPLIT;
				tree[2 * n + 1] = NODE_FREE;
				tree[2 * n + 2] = NODE_FREE;
			end
			n = 2 * n + 1 + ((j >> (d - 1 - k)) & 1);
		end
		tree[n] = NODE_ALLOC;
	endfunction

	function automatic void coalesce(int start);
		int n;
		int b;
		int p;
		n = start;
		while (n > 0) begin
			b = (n & 1) ? n + 1 : n - 1;
			p = (n - 1) / 2;
			if (tree[n] != NODE_FREE || tree[b] != NODE_FREE)
				break;
			tree[n] = NODE_UNUSED;
			tree[b] = NODE_UNUSED;
			tree[p] = NODE_FREE;
			n = p;
		end
	endfunction

	function automatic rsp_t predict_allocator(req_t r);
		rsp_t e;
		int order;
		int d;
		int bytes;
		e = '0;
		if (r.mode == 1'b0) begin
			order = -1;
			for (int i = 0; i <= ORDERS; i++)
				if (order < 0 && r.req_size < (MIN_BYTES << i))
					order = i;
			if (r.req_size == 0 || order < 0) begin
				e.status = STAT_BAD_SIZE;
			end else begin
				d = ORDERS - order;
				bytes = MIN_BYTES << order;
				e.status = STAT_NO_ROOM;
				for (int j = 0; j < (1 << d); j++) begin
					if (slot_open(d, j)) begin
						claim_slot(d, j);
						e.status = STAT_OK;
						e.result_offset = 12'(j * bytes);
						e.block_bytes = 13'(bytes);
						live_offsets.push_back(12'(j * bytes));
						break;
					end
				end
			end
		end else begin
			e.status = STAT_NOT_FOUND;
			for (int n = 0; n < NODES; n++) begin
				if (tree[n] == NODE_ALLOC) begin
					d = level_of(n);
					bytes = MIN_BYTES << (ORDERS - d);
					if ((n - ((1 << d) - 1)) * bytes == r.block_offset) begin
						tree[n] = NODE_FREE;
						e.status = STAT_OK;
						e.result_offset = r.block_offset;
						e.block_bytes = 13'(bytes);
						coalesce(n);
						foreach (live_offsets[k])
							if (live_offsets[k] == r.block_offset) begin
								live_offsets.delete(k);
								break;
							end
						break;
					end
				end
			end
		end
		e.ok = (e.status == STAT_OK);
		return e;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	initial begin
		rsp_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready) begin
				if (pending.size() == 0) begin
					report_mismatch("unexpected beat", 1, 0);
				end else begin
					want = pending.pop_front();
					if (rsp.payload.ok !== want.ok)
						report_mismatch("ok", rsp.payload.ok, want.ok);
					if (rsp.payload.status !== want.status)
						report_mismatch("status", rsp.payload.status, want.status);
					if (rsp.payload.result_offset !== want.result_offset)
						report_mismatch("result_offset", rsp.payload.result_offset,
							want.result_offset);
					if (rsp.payload.block_bytes !== want.block_bytes)
						report_mismatch("block_bytes", rsp.payload.block_bytes,
							want.block_bytes);
				end
			end
		end
	end

	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_beat(bit mode, int size, int offset);
		req_t r;
		r.mode = mode;
		r.req_size = 13'(size);
		r.block_offset = 12'(offset);
		while ($urandom_range(99) < send_idle_pct)
			@(posedge clk);
		req.valid <= 1'b1;
		req.payload <= r;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		pending.push_back(predict_allocator(r));
		req.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_sizes();
		send_beat(1'b0, 0, 0);
		send_beat(1'b0, HEAP, 0);
		send_beat(1'b0, 8191, 0);
		send_beat(1'b0, HEAP - 1, 0);
		send_beat(1'b0, 1, 0);
		send_beat(1'b1, 0, 4095);
		send_beat(1'b1, 8191, 0);
		send_beat(1'b1, 0, 0);
		send_beat(1'b0, 31, 0);
		send_beat(1'b0, 32, 0);
		send_beat(1'b0, 2047, 0);
		send_beat(1'b0, 1024, 0);
		send_beat(1'b1, 0, 2048);
		send_beat(1'b1, 0, 32);
		send_beat(1'b1, 0, 0);
		send_beat(1'b1, 0, 64);
		send_beat(1'b1, 0, 2048);
	endtask

	task automatic test_fill();
		for (int i = 0; i < (1 << ORDERS) + 2; i++)
			send_beat(1'b0, $urandom_range(1, MIN_BYTES - 1), 0);
		drain();
		while (live_offsets.size() != 0)
			send_beat(1'b1, $urandom, live_offsets[$urandom_range(live_offsets.size() - 1)]);
		drain();
	endtask

	task automatic test_random(int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 50)
				send_beat(1'b0, (pick < 40) ? $urandom_range(1, 300) :
					$urandom_range(1, HEAP - 1), $urandom);
			else if (pick < 88 && live_offsets.size() != 0)
				send_beat(1'b1, $urandom,
					live_offsets[$urandom_range(live_offsets.size() - 1)]);
			else
				send_beat(pick[0], $urandom, $urandom);
		end
	endtask

	initial begin
		errors = 0;
		foreach (tree[n])
			tree[n] = NODE_UNUSED;
		tree[0] = NODE_FREE;
		send_idle_pct = 27;
		recv_idle_pct = 63;
		req.valid = 1'b0;
		req.payload = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_sizes();
		test_random(190);
		drain();
		send_idle_pct = 63;
		recv_idle_pct = 27;
		test_fill();
		test_random(190);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(195);
		drain();
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("tb_buddy_block_allocator_unit: clean");
		else
			$display("tb_buddy_block_allocator_unit: errors");
		$finish;
	end
endmodule
